[rtl/quaternion_vector_rotation_core_macros.svh]
// Assertion macros shared by the quaternion rotation RTL.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef QUATERNION_VECTOR_ROTATION_CORE_MACROS_SVH
`define QUATERNION_VECTOR_ROTATION_CORE_MACROS_SVH

// Checked only outside reset.
`define QVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define QVR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/qvr_pkg.sv]
// Types, widths and step functions for the quaternion rotation core.
// Used by qvr_norm and quaternion_vector_rotation_core.
`timescale 1ns / 1ps

package qvr_pkg;

  localparam int QuatW     = 16;
  localparam int FracBits  = 14;
  localparam int VecW      = 16;
  localparam int OutW      = 17;
  localparam int TolW      = 14;
  localparam int InDataW   = 112;
  localparam int OutDataW  = 56;
  localparam int SqW       = 31;
  localparam int SumW      = 34;
  localparam int RootW     = 18;
  localparam int SqrtSteps = SumW / 2;
  localparam int NumW      = 31;
  localparam int DivRemW   = 33;
  localparam int QuotW     = 16;
  localparam int DivSteps  = QuotW;
  localparam int NormW     = 17;
  localparam int ProdW     = NormW + VecW;
  localparam int CrossW    = ProdW + 1;
  localparam int DProdW    = NormW + CrossW;
  localparam int TW        = DProdW + 3;
  localparam int RW        = TW - (2 * FracBits - 1) + 1;

  typedef logic signed [QuatW-1:0] quat_t;
  typedef logic signed [VecW-1:0]  vec_t;
  typedef logic signed [NormW-1:0] nquat_t;

  typedef struct packed {
    quat_t w;
    quat_t x;
    quat_t y;
    quat_t z;
    vec_t  vx;
    vec_t  vy;
    vec_t  vz;
    logic  zero;
  } qvr_item_t;

  typedef struct packed {
    nquat_t w;
    nquat_t x;
    nquat_t y;
    nquat_t z;
    vec_t   vx;
    vec_t   vy;
    vec_t   vz;
    logic   zero;
  } qvr_norm_t;

  typedef struct packed {
    logic [SumW:0] rem;
    logic [SumW:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [DivRemW-1:0] rem;
    logic [QuotW-1:0]   quot;
  } div_t;

  // One digit of the bitwise integer square root.
  function automatic sqrt_t sqrt_step(sqrt_t a, logic [SumW:0] bitv);
    sqrt_t         b;
    logic [SumW:0] trial;
    trial = a.root + bitv;
    if (a.rem >= trial) begin
      b.rem  = a.rem - trial;
      b.root = (a.root >> 1) + bitv;
    end else begin
      b.rem  = a.rem;
      b.root = a.root >> 1;
    end
    return b;
  endfunction

  // One quotient bit of restoring division against a pre-shifted divisor.
  function automatic div_t div_step(div_t a, logic [DivRemW-1:0] dsh);
    div_t b;
    logic ge;
    ge     = (a.rem >= dsh);
    b.rem  = ge ? (a.rem - dsh) : a.rem;
    b.quot = {a.quot[QuotW-2:0], ge};
    return b;
  endfunction

endpackage

[rtl/qvr_norm.sv]
// Quaternion norm and normalization pipeline: squares, pipelined square root,
// tolerance check and four pipelined restoring dividers. Depends on qvr_pkg.
`timescale 1ns / 1ps

module qvr_norm (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       ce,
  input  logic                       in_valid,
  input  qvr_pkg::qvr_item_t         in_item,
  input  logic [qvr_pkg::TolW-1:0]   tol,
  output logic                       out_valid,
  output qvr_pkg::qvr_norm_t         out_item
);
  import qvr_pkg::*;

  localparam logic [RootW-1:0] One = RootW'(1) << FracBits;

  logic      v0, v1, v2;
  qvr_item_t it0, it1, it2;
  logic [SqW-1:0] sq [4];
  logic [SumW-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (ce) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      it0   <= in_item;
      it1   <= it0;
      sq[0] <= SqW'(it0.w) * SqW'(it0.w);
      sq[1] <= SqW'(it0.x) * SqW'(it0.x);
      sq[2] <= SqW'(it0.y) * SqW'(it0.y);
      sq[3] <= SqW'(it0.z) * SqW'(it0.z);
      it2   <= it1;
      sum   <= SumW'(sq[0]) + SumW'(sq[1]) + SumW'(sq[2]) + SumW'(sq[3]);
    end
  end

  logic      sv [SqrtSteps+1];
  qvr_item_t si [SqrtSteps+1];
  sqrt_t     sr [SqrtSteps+1];

  assign sv[0]      = v2;
  assign si[0]      = it2;
  assign sr[0].rem  = (SumW+1)'(sum);
  assign sr[0].root = '0;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [SumW:0] Bit = (SumW+1)'(1) << (SumW - 2 - 2 * k);
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (ce) begin
        sv[k+1] <= sv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        si[k+1] <= si[k];
        sr[k+1] <= sqrt_step(sr[k], Bit);
      end
    end
  end

  logic [RootW-1:0] n_round, n_fix, dev;
  logic [NumW-1:0]  num [4];
  logic [3:0]       neg_c;
  quat_t            qc [4];

  always_comb begin
    n_round = RootW'(sr[SqrtSteps].root) +
              RootW'(sr[SqrtSteps].rem > sr[SqrtSteps].root);
    n_fix   = (n_round == '0) ? RootW'(1) : n_round;
    dev     = (n_fix > One) ? (n_fix - One) : (One - n_fix);
    qc[0]   = si[SqrtSteps].w;
    qc[1]   = si[SqrtSteps].x;
    qc[2]   = si[SqrtSteps].y;
    qc[3]   = si[SqrtSteps].z;
    for (int i = 0; i < 4; i++) begin
      neg_c[i] = qc[i][QuatW-1];
      num[i]   = (NumW'($unsigned(neg_c[i] ? (QuatW'(0) - qc[i]) : qc[i])) << FracBits)
                 + NumW'(n_fix >> 1);
    end
  end

  logic             dvv [DivSteps+1];
  qvr_item_t        di  [DivSteps+1];
  logic [RootW-1:0] dn  [DivSteps+1];
  logic             dno [DivSteps+1];
  logic [3:0]       dng [DivSteps+1];
  div_t             dd  [DivSteps+1][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (ce) begin
      dvv[0] <= sv[SqrtSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      di[0]  <= si[SqrtSteps];
      dn[0]  <= n_fix;
      dno[0] <= (dev > RootW'(tol));
      dng[0] <= neg_c;
      for (int i = 0; i < 4; i++) begin
        dd[0][i].rem  <= DivRemW'(num[i]);
        dd[0][i].quot <= '0;
      end
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[k+1] <= 1'b0;
      end else if (ce) begin
        dvv[k+1] <= dvv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        di[k+1]  <= di[k];
        dn[k+1]  <= dn[k];
        dno[k+1] <= dno[k];
        dng[k+1] <= dng[k];
        for (int i = 0; i < 4; i++) begin
          dd[k+1][i] <= div_step(dd[k][i],
                                 DivRemW'(dn[k]) << (DivSteps - 1 - k));
        end
      end
    end
  end

  nquat_t    qsel [4];
  quat_t     qraw [4];
  qvr_norm_t nsel;

  always_comb begin
    qraw[0] = di[DivSteps].w;
    qraw[1] = di[DivSteps].x;
    qraw[2] = di[DivSteps].y;
    qraw[3] = di[DivSteps].z;
    for (int i = 0; i < 4; i++) begin
      if (dno[DivSteps]) begin
        qsel[i] = dng[DivSteps][i] ? -nquat_t'({1'b0, dd[DivSteps][i].quot})
                                   :  nquat_t'({1'b0, dd[DivSteps][i].quot});
      end else begin
        qsel[i] = NormW'(qraw[i]);
      end
    end
    nsel.w    = qsel[0];
    nsel.x    = qsel[1];
    nsel.y    = qsel[2];
    nsel.z    = qsel[3];
    nsel.vx   = di[DivSteps].vx;
    nsel.vy   = di[DivSteps].vy;
    nsel.vz   = di[DivSteps].vz;
    nsel.zero = di[DivSteps].zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= dvv[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_item <= nsel;
    end
  end

endmodule

[rtl/quaternion_vector_rotation_core.sv]
// Throughput: one rotation per cycle unless a result waits on m_axis_tready; the 17-step
// square root and the 16-step dividers are fully pipelined, one stage per digit.
// A result waiting on a low m_axis_tready holds the whole pipeline and s_axis_tready.
// Reset (rst, synchronous) clears all valid bits and sets norm_tolerance to 0.
// Depends on qvr_pkg, qvr_norm and quaternion_vector_rotation_core_macros.svh.
`timescale 1ns / 1ps
`include "quaternion_vector_rotation_core_macros.svh"

module quaternion_vector_rotation_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qvr_pkg::TolW-1:0]       cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z (16 bits each)
  input  logic [qvr_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_x, out_y, out_z (17 bits each), 5 zero bits
  output logic [qvr_pkg::OutDataW-1:0]   m_axis_tdata,
  // zero_quat, saturated
  output logic [1:0]                     m_axis_tuser
);
  import qvr_pkg::*;

  localparam logic signed [RW-1:0] OutMax = RW'((1 << (OutW - 1)) - 1);
  localparam logic signed [RW-1:0] OutMin = -RW'(1 << (OutW - 1));
  localparam logic signed [TW-1:0] Half   = TW'(1) << (2 * FracBits - 2);

  logic            ce;
  logic [TolW-1:0] norm_tolerance;
  qvr_item_t       in_item;
  logic            nv;
  qvr_norm_t       nit;

  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_tolerance <= '0;
    end else if (cfg_valid) begin
      norm_tolerance <= cfg_data;
    end
  end

  always_comb begin
    in_item.w    = s_axis_tdata[15:0];
    in_item.x    = s_axis_tdata[31:16];
    in_item.y    = s_axis_tdata[47:32];
    in_item.z    = s_axis_tdata[63:48];
    in_item.vx   = s_axis_tdata[79:64];
    in_item.vy   = s_axis_tdata[95:80];
    in_item.vz   = s_axis_tdata[111:96];
    in_item.zero = (s_axis_tdata[63:0] == '0);
  end

  qvr_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (s_axis_tvalid),
    .in_item  (in_item),
    .tol      (norm_tolerance),
    .out_valid(nv),
    .out_item (nit)
  );

  logic      va, vb, vc, vd;
  qvr_norm_t ia, ib, ic, id;
  logic signed [ProdW-1:0]  pa [6];
  logic signed [CrossW-1:0] cr [3];
  logic signed [DProdW-1:0] dp [6];
  logic signed [DProdW-1:0] wc [3];
  logic signed [TW-1:0]     t  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (ce) begin
      va <= nv;
      vb <= va;
      vc <= vb;
      vd <= vc;
      m_axis_tvalid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ia    <= nit;
      pa[0] <= ProdW'(nit.y) * ProdW'(nit.vz);
      pa[1] <= ProdW'(nit.z) * ProdW'(nit.vy);
      pa[2] <= ProdW'(nit.z) * ProdW'(nit.vx);
      pa[3] <= ProdW'(nit.x) * ProdW'(nit.vz);
      pa[4] <= ProdW'(nit.x) * ProdW'(nit.vy);
      pa[5] <= ProdW'(nit.y) * ProdW'(nit.vx);

      ib    <= ia;
      cr[0] <= CrossW'(pa[0]) - CrossW'(pa[1]);
      cr[1] <= CrossW'(pa[2]) - CrossW'(pa[3]);
      cr[2] <= CrossW'(pa[4]) - CrossW'(pa[5]);

      ic    <= ib;
      dp[0] <= DProdW'(ib.y) * DProdW'(cr[2]);
      dp[1] <= DProdW'(ib.z) * DProdW'(cr[1]);
      dp[2] <= DProdW'(ib.z) * DProdW'(cr[0]);
      dp[3] <= DProdW'(ib.x) * DProdW'(cr[2]);
      dp[4] <= DProdW'(ib.x) * DProdW'(cr[1]);
      dp[5] <= DProdW'(ib.y) * DProdW'(cr[0]);
      for (int i = 0; i < 3; i++) begin
        wc[i] <= DProdW'(ib.w) * DProdW'(cr[i]);
      end

      id <= ic;
      for (int i = 0; i < 3; i++) begin
        t[i] <= TW'(dp[2*i]) - TW'(dp[2*i+1]) + TW'(wc[i]) + Half;
      end
    end
  end

  logic signed [TW-1:0]   off [3];
  logic signed [RW-1:0]   rr  [3];
  logic signed [OutW-1:0] res [3];
  logic [2:0]             clip;
  vec_t                   vin [3];

  always_comb begin
    vin[0] = id.vx;
    vin[1] = id.vy;
    vin[2] = id.vz;
    for (int i = 0; i < 3; i++) begin
      off[i] = t[i] >>> (2 * FracBits - 1);
      rr[i]  = id.zero ? RW'(vin[i]) : (RW'(vin[i]) + RW'(off[i]));
      priority if (rr[i] > OutMax) begin
        res[i]  = OutW'(OutMax);
        clip[i] = 1'b1;
      end else if (rr[i] < OutMin) begin
        res[i]  = OutW'(OutMin);
        clip[i] = 1'b1;
      end else begin
        res[i]  = OutW'(rr[i]);
        clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_axis_tdata <= {(OutDataW - 3 * OutW)'(0), res[2], res[1], res[0]};
      m_axis_tuser <= {|clip, id.zero};
    end
  end

  logic at_rail;
  assign at_rail = (^m_axis_tdata[16:15]) || (^m_axis_tdata[33:32]) || (^m_axis_tdata[50:49]);

  `QVR_ASSERT_ALWAYS(a_reset_clears, rst |=> !m_axis_tvalid, "valid output right after reset")
  `QVR_ASSERT(a_zero_no_sat, m_axis_tvalid |-> !(&m_axis_tuser), "pass-through saturated")
  `QVR_ASSERT(a_sat_extreme, m_axis_tvalid && m_axis_tuser[1] |-> at_rail, "saturated off rail")
  `QVR_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[OutDataW-1:3*OutW] == '0, "padding set")

endmodule

[tb/tb.sv]
// Self-checking bench for quaternion_vector_rotation_core: directed and random rotations,
// predicted in fixed point and compared field by field. Depends on qvr_pkg and the core.
`timescale 1ns / 1ps

module tb;
  import qvr_pkg::*;

  typedef struct packed {
    logic signed [16:0] ox, oy, oz;
    logic               zq, sat;
  } rot_t;

  typedef struct {
    logic [15:0] w, x, y, z, vx, vy, vz;
    logic        chk;
    rot_t        r;
  } row_t;

  logic clk = 1'b0, rst = 1'b1;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [TolW-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0, s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  logic [13:0] tolerance;
  rot_t rotations_due[$];
  int errors = 0;
  int stall_mode = 0;
  row_t rows[$];

  quaternion_vector_rotation_core uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #4ms;
    $display("tb: done, errors");
    $finish;
  end

  function automatic logic signed [63:0] rnd_div(logic signed [63:0] q, longint unsigned n);
    longint unsigned mag, res;
    mag = (q < 0) ? -q : q;
    res = ((mag << 14) + n / 2) / n;
    return (q < 0) ? -$signed(res) : $signed(res);
  endfunction

  function automatic logic signed [16:0] clamp17(logic signed [63:0] v, inout logic sat);
    if (v > 65535) begin
      sat = 1'b1;
      return 17'sd65535;
    end
    if (v < -65536) begin
      sat = 1'b1;
      return -17'sd65536;
    end
    return v[16:0];
  endfunction

  function automatic rot_t rotate(logic [15:0] qw, qx, qy, qz, vxi, vyi, vzi);
    rot_t r;
    logic signed [63:0] q[4], v[3], c[3], d[3], t, o[3];
    longint unsigned s, rem, root, b, dev;
    r.sat = 1'b0;
    q[0] = 64'($signed(qw)); q[1] = 64'($signed(qx));
    q[2] = 64'($signed(qy)); q[3] = 64'($signed(qz));
    v[0] = 64'($signed(vxi)); v[1] = 64'($signed(vyi)); v[2] = 64'($signed(vzi));
    if (q[0] == 0 && q[1] == 0 && q[2] == 0 && q[3] == 0) begin
      r.ox = clamp17(v[0], r.sat);
      r.oy = clamp17(v[1], r.sat);
      r.oz = clamp17(v[2], r.sat);
      r.zq = 1'b1;
      return r;
    end
    s = 0;
    for (int i = 0; i < 4; i++) s += q[i] * q[i];
    rem = s; root = 0; b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    if (rem > root) root++;
    if (root == 0) root = 1;
    dev = (root > 16384) ? root - 16384 : 16384 - root;
    if (dev > tolerance)
      for (int i = 0; i < 4; i++) q[i] = rnd_div(q[i], root);
    c[0] = q[2] * v[2] - q[3] * v[1];
    c[1] = q[3] * v[0] - q[1] * v[2];
    c[2] = q[1] * v[1] - q[2] * v[0];
    d[0] = q[2] * c[2] - q[3] * c[1];
    d[1] = q[3] * c[0] - q[1] * c[2];
    d[2] = q[1] * c[1] - q[2] * c[0];
    for (int i = 0; i < 3; i++) begin
      t = d[i] + q[0] * c[i] + (64'sd1 <<< 26);
      o[i] = v[i] + (t >>> 27);
    end
    r.ox = clamp17(o[0], r.sat);
    r.oy = clamp17(o[1], r.sat);
    r.oz = clamp17(o[2], r.sat);
    r.zq = 1'b0;
    return r;
  endfunction

  always @(negedge clk) begin
    if (!rst) begin
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    rot_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (rotations_due.size() == 0) begin
        $display("%0t: unexpected result %h/%b", $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = rotations_due.pop_front();
        if (m_axis_tdata[16:0] !== want.ox || m_axis_tdata[33:17] !== want.oy ||
            m_axis_tdata[50:34] !== want.oz || m_axis_tdata[55:51] !== 5'd0 ||
            m_axis_tuser[0] !== want.zq || m_axis_tuser[1] !== want.sat) begin
          $display("%0t: expected x=%0d y=%0d z=%0d zq=%b sat=%b, got x=%0d y=%0d z=%0d zq=%b sat=%b",
                   $time, want.ox, want.oy, want.oz, want.zq, want.sat,
                   $signed(m_axis_tdata[16:0]), $signed(m_axis_tdata[33:17]),
                   $signed(m_axis_tdata[50:34]), m_axis_tuser[0], m_axis_tuser[1]);
          errors++;
        end
      end
    end
  end

  task automatic write_tolerance(logic [13:0] tol);
    cfg_data  <= tol;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tolerance = tol;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_rotation(row_t r);
    rot_t p;
    s_axis_tdata  <= {r.vz, r.vy, r.vx, r.z, r.y, r.x, r.w};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    p = rotate(r.w, r.x, r.y, r.z, r.vx, r.vy, r.vz);
    if (r.chk && p != r.r) begin
      $display("%0t: typed row expected %h, predicted %h", $time, r.r, p);
      errors++;
    end
    rotations_due.push_back(r.chk ? r.r : p);
    @(negedge clk);
  endtask

  task automatic drain();
    int n;
    n = 0;
    while (rotations_due.size() != 0) @(negedge clk);
    while (n < 60) begin
      @(negedge clk);
      n++;
    end
  endtask

  function automatic row_t mk(int w, x, y, z, vx, vy, vz);
    row_t r;
    r.w = 16'(w); r.x = 16'(x); r.y = 16'(y); r.z = 16'(z);
    r.vx = 16'(vx); r.vy = 16'(vy); r.vz = 16'(vz);
    r.chk = 1'b0;
    r.r = '0;
    return r;
  endfunction

  function automatic row_t mkx(int w, x, y, z, vx, vy, vz, ox, oy, oz, zq, sat);
    row_t r;
    r = mk(w, x, y, z, vx, vy, vz);
    r.chk = 1'b1;
    r.r.ox = 17'(ox); r.r.oy = 17'(oy); r.r.oz = 17'(oz);
    r.r.zq = 1'(zq); r.r.sat = 1'(sat);
    return r;
  endfunction

  function automatic logic [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 8192) - 4096);
      default: return 16'(($urandom_range(0, 1) ? 16'h7fff : 16'h8000) ^ $urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    int sent, burst, gap, tols[6];
    row_t r;
    tols = '{0, 16383, 40, 1, 8191, 0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    tolerance = 14'd0;

    rows.push_back(mkx(0, 0, 0, 0, 32767, -32768, 5, 32767, -32768, 5, 1, 0));
    rows.push_back(mkx(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    rows.push_back(mkx(16384, 0, 0, 0, 32767, -32768, 123, 32767, -32768, 123, 0, 0));
    rows.push_back(mkx(-16384, 0, 0, 0, 1000, -7, 0, 1000, -7, 0, 0, 0));
    rows.push_back(mkx(0, 16384, 0, 0, 10, 20, 30, 10, -20, -30, 0, 0));
    rows.push_back(mkx(0, 0, 0, 16384, -32768, -32768, 1, 32768, 32768, 1, 0, 0));
    rows.push_back(mkx(32767, 0, 0, 0, 1, 2, 3, 1, 2, 3, 0, 0));
    rows.push_back(mkx(8192, 0, 0, 0, 4, 5, 6, 4, 5, 6, 0, 0));
    rows.push_back(mk(11585, 0, 0, 11585, 32767, 32767, -32768));
    rows.push_back(mk(-32768, -32768, -32768, -32768, 32767, -32768, 32767));
    rows.push_back(mk(32767, 32767, 32767, 32767, -32768, 32767, -32768));
    rows.push_back(mk(1, 0, 0, 0, 100, 200, 300));
    rows.push_back(mk(0, 1, -1, 1, -32768, -32768, -32768));
    rows.push_back(mk(0, 23170, 23170, 0, 32767, 0, -32768));
    rows.push_back(mk(16000, 2000, -3000, 500, 12345, -23456, 3210));

    for (int ph = 0; ph < 6; ph++) begin
      write_tolerance(14'(tols[ph]));
      stall_mode = ph % 3;
      if (ph == 0) foreach (rows[i]) send_rotation(rows[i]);
      sent = 0;
      while (sent < 200) begin
        burst = $urandom_range(1, 20);
        while (burst > 0 && sent < 200) begin
          case ($urandom_range(0, 9))
            0: r = mk(0, 0, 0, 0, rand_comp(0), rand_comp(0), rand_comp(0));
            1, 2: r = mk(rand_comp(2), rand_comp(2), rand_comp(2), rand_comp(2),
                         rand_comp(2), rand_comp(2), rand_comp(2));
            3, 4, 5: r = mk(16384 + $urandom_range(0, 80) - 40, $urandom_range(0, 80) - 40,
                            rand_comp(1), rand_comp(1), rand_comp(0), rand_comp(0),
                            rand_comp(0));
            default: r = mk(rand_comp(0), rand_comp(0), rand_comp(0), rand_comp(0),
                            rand_comp(0), rand_comp(0), rand_comp(0));
          endcase
          send_rotation(r);
          burst--;
          sent++;
        end
        gap = $urandom_range(0, 6);
        if (gap != 0 || sent >= 200) s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
